// ===== rtl/plcm_pkg.sv =====
package plcm_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int PosW       = 16;
  localparam int ChanW      = 8;
  localparam int XW         = PosW + 1;
  // divider: dividend wide enough for the shifted normalising numerator
  localparam int NumW       = 2 * PosW + 1;
  localparam int DenW       = XW;
  localparam int BlendW     = ChanW + XW + 1;

  localparam logic [1:0] RegMin   = 2'd0;
  localparam logic [1:0] RegMax   = 2'd1;
  localparam logic [1:0] RegCount = 2'd2;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdMap  = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

// ===== rtl/plcm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, carries a tag along.
module plcm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [plcm_pkg::NumW-1:0] in_num,
  input  logic [plcm_pkg::DenW-1:0] in_den,
  input  logic                      in_tag,
  output logic                      out_vld,
  output logic [plcm_pkg::NumW-1:0] out_quo,
  output logic                      out_tag
);
  localparam int NW = plcm_pkg::NumW;
  localparam int DW = plcm_pkg::DenW;

  logic [NW-1:0] num_r [1:NW];
  logic [DW-1:0] den_r [1:NW];
  logic [DW:0]   rem_r [1:NW];
  logic [NW-1:0] quo_r [1:NW];
  logic          tag_r [1:NW];
  logic          vld_r [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [NW-1:0] num_i;
    logic [DW-1:0] den_i;
    logic [DW:0]   rem_i;
    logic [NW-1:0] quo_i;
    logic          tag_i;
    logic          vld_i;
    logic [DW:0]   trial;
    logic          ge;

    // stage inputs: the port for the first stage, the previous stage otherwise
    if (s == 0) begin : g_head
      assign num_i = in_num;
      assign den_i = in_den;
      assign rem_i = '0;
      assign quo_i = '0;
      assign tag_i = in_tag;
      assign vld_i = in_vld;
    end else begin : g_body
      assign num_i = num_r[s];
      assign den_i = den_r[s];
      assign rem_i = rem_r[s];
      assign quo_i = quo_r[s];
      assign tag_i = tag_r[s];
      assign vld_i = vld_r[s];
    end

    assign trial = {rem_i[DW-1:0], num_i[NW-1-s]};
    assign ge    = trial >= {1'b0, den_i};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_i;
      end
      if (en) begin
        num_r[s+1] <= num_i;
        den_r[s+1] <= den_i;
        tag_r[s+1] <= tag_i;
        rem_r[s+1] <= ge ? trial - {1'b0, den_i} : trial;
        quo_r[s+1] <= {quo_i[NW-2:0], ge};
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign out_quo = quo_r[NW];
  assign out_tag = tag_r[NW];
endmodule

// ===== rtl/plcm_search.sv =====
// Parallel breakpoint compare and pair select, two register stages.
module plcm_search (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [plcm_pkg::XW-1:0] in_x,
  input  logic [plcm_pkg::CntW-1:0] in_n,
  input  logic [plcm_pkg::PosW-1:0] pos_tab [plcm_pkg::TableDepth],
  input  plcm_pkg::rgb_t          col_tab [plcm_pkg::TableDepth],
  output logic                    out_vld,
  output logic                    out_flat,
  output logic [plcm_pkg::XW-1:0] out_x,
  output logic [plcm_pkg::PosW-1:0] out_p0,
  output logic [plcm_pkg::PosW-1:0] out_p1,
  output plcm_pkg::rgb_t          out_c0,
  output plcm_pkg::rgb_t          out_c1
);
  localparam int D = plcm_pkg::TableDepth;
  localparam int IW = plcm_pkg::IdxW;

  // stage 1: compare x against every breakpoint
  logic [D-1:0] le_r;
  logic [plcm_pkg::XW-1:0] x_r;
  logic [IW-1:0] last_r;
  logic vld_r;
  logic [IW-1:0] last;

  always_comb begin
    last = IW'(in_n - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      x_r    <= in_x;
      last_r <= last;
      for (int j = 0; j < D; j++) begin
        le_r[j] <= in_x <= {1'b0, pos_tab[j]};
      end
    end
  end

  // stage 2: pick lowest index with x <= pos, or clamp
  logic [IW-1:0] sel;
  logic          hi_clamp;
  always_comb begin
    sel = last_r;
    for (int j = D - 1; j >= 1; j--) begin
      if (le_r[j] && IW'(j) < last_r) sel = IW'(j);
    end
    hi_clamp = x_r >= {1'b0, pos_tab[last_r]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_r;
    end
    if (en) begin
      out_x <= x_r;
      if (le_r[0]) begin
        out_flat <= 1'b1;
        out_c0   <= col_tab[0];
        out_c1   <= col_tab[0];
        out_p0   <= pos_tab[0];
        out_p1   <= pos_tab[0];
      end else if (hi_clamp) begin
        out_flat <= 1'b1;
        out_c0   <= col_tab[last_r];
        out_c1   <= col_tab[last_r];
        out_p0   <= pos_tab[last_r];
        out_p1   <= pos_tab[last_r];
      end else begin
        out_flat <= 1'b0;
        out_c0   <= col_tab[sel - 1'b1];
        out_c1   <= col_tab[sel];
        out_p0   <= pos_tab[sel - 1'b1];
        out_p1   <= pos_tab[sel];
      end
    end
  end
endmodule

// ===== rtl/piecewise_linear_colormap.sv =====
// An accepted map beat passes a 33-stage normalising divider, 2 search
// stages, 1 multiply stage, a 33-stage blend divider and 1 output stage.
// Throughput: one map beat per cycle while the output is not stalled.
// A load beat waits until every earlier map has read the table, then updates it.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers to min -32768, max 32767, count 2; the table is not cleared.
module piecewise_linear_colormap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [3:0]  in_entry_index,
  input  logic [15:0] in_entry_pos,
  input  logic [7:0]  in_entry_red,
  input  logic [7:0]  in_entry_green,
  input  logic [7:0]  in_entry_blue,
  input  logic signed [15:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);
  localparam int D  = plcm_pkg::TableDepth;
  localparam int XW = plcm_pkg::XW;
  localparam int BW = plcm_pkg::BlendW;
  localparam int NW = plcm_pkg::NumW;

  logic signed [15:0] min_r, max_r;
  logic [4:0] cnt_r;
  logic [plcm_pkg::CntW-1:0] n_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= -16'sd32768;
      max_r <= 16'sd32767;
      cnt_r <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        plcm_pkg::RegMin:   min_r <= cfg_data;
        plcm_pkg::RegMax:   max_r <= cfg_data;
        plcm_pkg::RegCount: cnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cnt_r < 5'd2) n_eff = plcm_pkg::CntW'(2);
    else if ({1'b0, cnt_r} > 6'(D)) n_eff = plcm_pkg::CntW'(D);
    else n_eff = plcm_pkg::CntW'(cnt_r);
  end

  // pipeline advances unless the output register holds an untaken beat
  logic en;
  assign en = !out_valid || out_ready;

  // maps that have not yet read the table; a load waits for them
  logic [5:0] fly_r, fly_nxt;
  assign in_ready = en && !(in_cmd == plcm_pkg::CmdLoad && fly_r != 6'd0);

  logic acc;
  assign acc = in_valid && in_ready;

  // breakpoint table
  logic [15:0]    pos_tab_r [D];
  plcm_pkg::rgb_t col_tab_r [D];
  always_ff @(posedge clk) begin
    if (acc && in_cmd == plcm_pkg::CmdLoad) begin
      pos_tab_r[in_entry_index] <= in_entry_pos;
      col_tab_r[in_entry_index] <= '{in_entry_red, in_entry_green, in_entry_blue};
    end
  end

  // normalise: clamp sample, form numerator and span
  logic [16:0] num, den;
  logic        dgen;
  always_comb begin
    logic signed [16:0] s, lo, hi;
    s  = 17'(in_sample);
    lo = 17'(min_r);
    hi = 17'(max_r);
    dgen = hi <= lo;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    num = 17'(s - lo);
    den = dgen ? 17'd1 : 17'(hi - lo);
    if (dgen) num = '0;
  end

  // quotient (num<<16)/den fits in 17 bits; feed a 33-bit dividend stage chain
  logic          nd_vld;
  logic [NW-1:0] nd_q;
  logic          nd_tag;
  plcm_div u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(acc && in_cmd == plcm_pkg::CmdMap),
    .in_num({num, 16'd0}), .in_den(den), .in_tag(1'b0),
    .out_vld(nd_vld), .out_quo(nd_q), .out_tag(nd_tag)
  );

  logic sr_vld, sr_flat;
  logic [XW-1:0] sr_x;
  logic [15:0] sr_p0, sr_p1;
  plcm_pkg::rgb_t sr_c0, sr_c1;
  plcm_search u_srch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(nd_vld),
    .in_x(nd_q[XW-1:0] | XW'(nd_tag)), .in_n(n_eff),
    .pos_tab(pos_tab_r), .col_tab(col_tab_r),
    .out_vld(sr_vld), .out_flat(sr_flat), .out_x(sr_x),
    .out_p0(sr_p0), .out_p1(sr_p1), .out_c0(sr_c0), .out_c1(sr_c1)
  );

  // count maps in from acceptance until they leave the search output
  always_comb begin
    fly_nxt = fly_r;
    if (acc && in_cmd == plcm_pkg::CmdMap) fly_nxt = fly_nxt + 6'd1;
    if (en && sr_vld) fly_nxt = fly_nxt - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fly_r <= '0;
    end else begin
      fly_r <= fly_nxt;
    end
  end

  // weighted sums per channel
  logic          mu_vld_r;
  logic [BW-1:0] sum_r [3];
  logic [16:0]   span_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else if (en) begin
      mu_vld_r <= sr_vld;
    end
    if (en) begin
      if (sr_flat) begin
        span_r <= 17'd1;
        sum_r[0] <= BW'(sr_c1.red);
        sum_r[1] <= BW'(sr_c1.green);
        sum_r[2] <= BW'(sr_c1.blue);
      end else begin
        span_r <= 17'({1'b0, sr_p1} - {1'b0, sr_p0});
        sum_r[0] <= BW'(sr_c0.red) * BW'(XW'(sr_p1) - sr_x)
                  + BW'(sr_c1.red) * BW'(sr_x - XW'(sr_p0));
        sum_r[1] <= BW'(sr_c0.green) * BW'(XW'(sr_p1) - sr_x)
                  + BW'(sr_c1.green) * BW'(sr_x - XW'(sr_p0));
        sum_r[2] <= BW'(sr_c0.blue) * BW'(XW'(sr_p1) - sr_x)
                  + BW'(sr_c1.blue) * BW'(sr_x - XW'(sr_p0));
      end
    end
  end

  // three blend dividers in lockstep
  logic [NW-1:0] bq [3];
  logic [2:0]    bv;
  logic          bt [3];
  for (genvar k = 0; k < 3; k++) begin : g_bd
    plcm_div u_bd (
      .clk(clk), .rst_n(rst_n), .en(en), .in_vld(mu_vld_r),
      .in_num(NW'(sum_r[k])), .in_den(span_r), .in_tag(1'b0),
      .out_vld(bv[k]), .out_quo(bq[k]), .out_tag(bt[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= bv[0];
    end
    if (en) begin
      out_red   <= bq[0][7:0] | 8'(bt[0]);
      out_green <= bq[1][7:0] | 8'(bt[1]);
      out_blue  <= bq[2][7:0] | 8'(bt[2]);
    end
  end

`ifndef SYNTH
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    bv[0] == bv[1] && bv[1] == bv[2])
    else $error("blend lanes out of step");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_blue))
    else $error("result lost under stall");
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");
`endif
endmodule
